// ===== rtl/core/terminal_line_editor_unit_macros.svh =====
// Assertion macros used by the line editor datapath.
`ifndef TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH
`define TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line editor check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define TLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line editor check failed: next-cycle implication");

`endif

// ===== rtl/core/tle_pkg.sv =====
// Shared types and constants of the terminal line editor.
`default_nettype none

package tle_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 6;
    localparam int CFG_IDX_W = 1;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ECHO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS = 1'b1;

    // Reset value of the line limit register
    localparam logic [CNT_W-1:0] MAX_CHARS_RST = 6'd31;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ECHO,
        S_BS1,
        S_SPACE,
        S_BS2,
        S_CR,
        S_LF,
        S_RD,
        S_DATA,
        S_TERM
    } state_t;

    typedef enum logic [2:0] {
        EM_ECHO,
        EM_BS,
        EM_SPACE,
        EM_CR,
        EM_LF,
        EM_DATA,
        EM_TERM
    } emit_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      load_byte;
        logic      store_char;
        logic      dec_count;
        logic      clear_count;
        logic      idx_clear;
        logic      idx_inc;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_cr;
        logic is_bs;
        logic is_print;
        logic count_zero;
        logic can_store;
        logic line_full;
        logic idx_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tle_ctrl.sv =====
// Sequencing state machine of the terminal line editor.
`default_nettype none

module tle_ctrl
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           in_valid,
    output logic          in_stall,
    input  wire tle_pkg::stat_t stat,
    output tle_pkg::cmd_t  cmd
);
    import tle_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (stat.is_cr)
                    state_next = S_CR;
                else if (stat.is_bs)
                    state_next = stat.count_zero ? S_IDLE : S_BS1;
                else if (stat.is_print)
                    state_next = S_ECHO;
                else
                    state_next = S_IDLE;
            end
            S_ECHO:
            begin
                if (stat.out_free)
                    state_next = stat.line_full ? S_CR : S_IDLE;
            end
            S_BS1:
            begin
                if (stat.out_free)
                    state_next = S_SPACE;
            end
            S_SPACE:
            begin
                if (stat.out_free)
                    state_next = S_BS2;
            end
            S_BS2:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            S_CR:
            begin
                if (stat.out_free)
                    state_next = S_LF;
            end
            S_LF:
            begin
                if (stat.out_free)
                    state_next = stat.count_zero ? S_TERM : S_RD;
            end
            S_RD:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (stat.out_free)
                    state_next = stat.idx_last ? S_TERM : S_RD;
            end
            S_TERM:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands, gated on a free output register where a result goes out
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_byte = in_valid;
            end
            S_DECODE:
            begin
                cmd.store_char = stat.is_print && stat.can_store;
                cmd.dec_count  = stat.is_bs && !stat.count_zero;
            end
            S_ECHO:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_sel  = EM_ECHO;
                cmd.emit_last = !stat.line_full;
            end
            S_BS1:
            begin
                cmd.emit     = stat.out_free;
                cmd.emit_sel = EM_BS;
            end
            S_SPACE:
            begin
                cmd.emit     = stat.out_free;
                cmd.emit_sel = EM_SPACE;
            end
            S_BS2:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_sel  = EM_BS;
                cmd.emit_last = 1'b1;
            end
            S_CR:
            begin
                cmd.emit     = stat.out_free;
                cmd.emit_sel = EM_CR;
            end
            S_LF:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_sel  = EM_LF;
                cmd.idx_clear = stat.out_free;
            end
            S_RD:
            begin
                cmd = '0;
            end
            S_DATA:
            begin
                cmd.emit     = stat.out_free;
                cmd.emit_sel = EM_DATA;
                cmd.idx_inc  = stat.out_free;
            end
            S_TERM:
            begin
                cmd.emit        = stat.out_free;
                cmd.emit_sel    = EM_TERM;
                cmd.emit_last   = 1'b1;
                cmd.clear_count = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tle_datapath.sv =====
// Line store, counters, configuration and output register of the line editor.
`default_nettype none

module tle_datapath
#(
    parameter int LINE_MAX = 32
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire [tle_pkg::BYTE_W-1:0]        rx_byte,
    input  wire                              cfg_we,
    input  wire [tle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [tle_pkg::CNT_W-1:0]         cfg_data,
    input  wire tle_pkg::cmd_t               cmd,
    output tle_pkg::stat_t                   stat,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [tle_pkg::BYTE_W-1:0]       out_byte,
    output logic                             dest,
    output logic [tle_pkg::CNT_W-1:0]        line_length,
    output logic                             last
);
    import tle_pkg::*;

`include "terminal_line_editor_unit_macros.svh"

    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam logic [CNT_W-1:0] LINE_MAX_C = CNT_W'(LINE_MAX);

    logic [BYTE_W-1:0] mem [LINE_MAX];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [BYTE_W-1:0] rx_reg;
    logic [CNT_W-1:0]  char_count_reg;
    logic [CNT_W-1:0]  char_count_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic              mask_echo_reg;
    logic [CNT_W-1:0]  max_chars_reg;
    logic [CNT_W-1:0]  limit;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              dest_reg;
    logic [CNT_W-1:0]  line_length_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_dest;
    logic [CNT_W-1:0]  emit_len;
    logic              emit_data;
    logic              emit_term;

    // Effective limit: at least one, at most the store depth
    always_comb
    begin
        if (max_chars_reg == '0)
            limit = CNT_W'(1);
        else if (max_chars_reg > LINE_MAX_C)
            limit = LINE_MAX_C;
        else
            limit = max_chars_reg;
    end

    // Status toward the controller
    always_comb
    begin
        stat.is_cr      = (rx_reg == CH_CR);
        stat.is_bs      = (rx_reg == CH_BS) || (rx_reg == CH_DEL);
        stat.is_print   = (rx_reg >= CH_SPACE) && (rx_reg <= CH_TILDE);
        stat.count_zero = (char_count_reg == '0);
        stat.can_store  = (char_count_reg < LINE_MAX_C);
        stat.line_full  = (char_count_reg >= limit);
        stat.idx_last   = ((idx_reg + CNT_W'(1)) == char_count_reg);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_echo_reg <= 1'b0;
            max_chars_reg <= MAX_CHARS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MASK_ECHO: mask_echo_reg <= cfg_data[0];
                CFG_MAX_CHARS: max_chars_reg <= cfg_data;
                default:       mask_echo_reg <= mask_echo_reg;
            endcase
        end
    end

    // Character count and read index
    always_comb
    begin
        char_count_next = char_count_reg;
        if (cmd.clear_count)
            char_count_next = '0;
        else if (cmd.store_char)
            char_count_next = char_count_reg + CNT_W'(1);
        else if (cmd.dec_count)
            char_count_next = char_count_reg - CNT_W'(1);

        idx_next = idx_reg;
        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            char_count_reg <= char_count_next;
            idx_reg        <= idx_next;
        end
    end

    // Received byte latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
            rx_reg <= rx_byte;
    end

    // Line store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store_char)
            mem[char_count_reg[AW-1:0]] <= rx_reg;
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    // Result select
    always_comb
    begin
        emit_byte = CH_NUL;
        emit_dest = 1'b0;
        emit_len  = '0;
        case (cmd.emit_sel)
            EM_ECHO:  emit_byte = mask_echo_reg ? CH_STAR : rx_reg;
            EM_BS:    emit_byte = CH_BS;
            EM_SPACE: emit_byte = CH_SPACE;
            EM_CR:    emit_byte = CH_CR;
            EM_LF:    emit_byte = CH_LF;
            EM_DATA:
            begin
                emit_byte = rd_data_reg;
                emit_dest = 1'b1;
            end
            EM_TERM:
            begin
                emit_dest = 1'b1;
                emit_len  = char_count_reg;
            end
            default:  emit_byte = CH_NUL;
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg    <= emit_byte;
            dest_reg        <= emit_dest;
            line_length_reg <= emit_len;
            last_reg        <= cmd.emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign dest        = dest_reg;
    assign line_length = line_length_reg;
    assign last        = last_reg;

    // Checks
    assign emit_data = cmd.emit && (cmd.emit_sel == EM_DATA);
    assign emit_term = cmd.emit && (cmd.emit_sel == EM_TERM);

    `TLE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, char_count_reg <= LINE_MAX_C)
    `TLE_ASSERT_IMP(a_dec_nonempty, clk, rst_n, cmd.dec_count, char_count_reg != '0)
    `TLE_ASSERT_IMP(a_read_in_line, clk, rst_n, emit_data, idx_reg < char_count_reg)
    `TLE_ASSERT_NXT(a_term_clears, clk, rst_n, emit_term, char_count_reg == '0)
    `TLE_ASSERT_IMP(a_emit_slot_free, clk, rst_n, cmd.emit, !out_valid_reg || !out_stall)

endmodule

`default_nettype wire

// ===== rtl/core/terminal_line_editor_unit.sv =====
// A request is decoded in the cycle after acceptance; its first result goes from the emit state into the
// output register once that register is free. Echo and control results go out one per cycle while the
// output is not stalled; each stored line byte is read from the line store (S_RD), then registered (S_DATA).
// Rate: one request at a time; the next is accepted once all results of the current one are issued.
// Reset (rst_n, async low): count cleared, mask_echo 0, max_chars 31; line store contents undefined.
`default_nettype none

module terminal_line_editor_unit
#(
    parameter int LINE_MAX = 32
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire [tle_pkg::BYTE_W-1:0]    rx_byte,
    input  wire                          cfg_we,
    input  wire [tle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [tle_pkg::CNT_W-1:0]     cfg_data,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [tle_pkg::BYTE_W-1:0]   out_byte,
    output logic                         dest,
    output logic [tle_pkg::CNT_W-1:0]    line_length,
    output logic                         last
);
    import tle_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    tle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and result path
    tle_datapath
    #(
        .LINE_MAX (LINE_MAX)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .dest        (dest),
        .line_length (line_length),
        .last        (last)
    );

endmodule

`default_nettype wire
